// ===== sv/vrsu_pkg.sv =====
// ----------------------------------------------------------------------------
// vrsu_pkg
// Types, codes and tables shared by the video register scroll unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vrsu_pkg;

   // Payload widths of the two channels
   localparam int unsigned REQ_DATA_W = 16;  // reg_select, write_data, first_line, pad
   localparam int unsigned RSP_DATA_W = 72;  // 66 result bits, padded to bytes
   localparam int unsigned RSP_BITS_W = 66;

   // Input operation kinds (req_tuser)
   typedef enum logic {
      OP_REG_WRITE = 1'b0,
      OP_SCANLINE  = 1'b1
   } op_type;

   // Register offsets from the register window base
   typedef enum logic [2:0] {
      REG_CONTROL_ONE = 3'd0,
      REG_CONTROL_TWO = 3'd1,
      REG_STATUS      = 3'd2,
      REG_OAM_ADDR    = 3'd3,
      REG_OAM_DATA    = 3'd4,
      REG_SCROLL      = 3'd5,
      REG_ADDRESS     = 3'd6,
      REG_DATA        = 3'd7
   } reg_sel_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_MIRROR_MODE = 1'b0,
      CSR_WRITE_BLOCK = 1'b1
   } csr_index_type;

   // Nametable mirroring modes; other codes act as single low
   localparam logic [2:0] MIRROR_HORIZONTAL  = 3'd0;
   localparam logic [2:0] MIRROR_VERTICAL    = 3'd1;
   localparam logic [2:0] MIRROR_SINGLE_LOW  = 3'd2;
   localparam logic [2:0] MIRROR_SINGLE_HIGH = 3'd3;
   localparam logic [2:0] MIRROR_FOUR_SCREEN = 3'd4;

   localparam logic [15:0] ACCESS_RESET   = 16'h2000;
   localparam logic [15:0] TABLE_LOW      = 16'h2000;
   localparam logic [15:0] TABLE_HIGH     = 16'h3EFF;
   localparam logic [15:0] PALETTE_MIRROR = 16'h3F10;
   localparam logic [4:0]  COARSE_Y_LAST  = 5'd29;
   localparam logic [4:0]  COARSE_Y_MAX   = 5'd31;

   // Result item; last member sits in the lowest bits
   typedef struct packed {
      logic [2:0]  scroll_fine_x;
      logic [14:0] scroll_address;
      logic [7:0]  oam_address;
      logic        oam_write;
      logic        palette_copy;
      logic [9:0]  table_offset;
      logic [1:0]  table_bank;
      logic        table_write;
      logic [7:0]  vram_data;
      logic [15:0] vram_address;
      logic        vram_write;
   } result_type;

   // Physical nametable for a logical quadrant under a mirroring mode
   function automatic logic [1:0] bank_map(input logic [2:0] mode, input logic [1:0] quad);
      logic [1:0] bank;
      begin
         case (mode)
            MIRROR_HORIZONTAL:  bank = {1'b0, quad[1]};
            MIRROR_VERTICAL:    bank = {1'b0, quad[0]};
            MIRROR_SINGLE_HIGH: bank = 2'd1;
            MIRROR_FOUR_SCREEN: bank = quad;
            default:            bank = 2'd0;
         endcase
         return bank;
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/video_register_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// video_register_scroll_unit
// Loopy-style scroll and register unit of a tile-based video processor.
//
// Each request item is either a CPU write to one of eight video registers
// (req_tuser = 0) or a scanline start (req_tuser = 1); each gives exactly one
// response item. The scroll state is updated and the response is captured in the
// output register at the edge that accepts the request, and a new request is
// taken every cycle as long as the output register is empty or being drained in
// the same cycle. Offset 4 writes report a sprite memory write, offset 7 writes
// (unless blocked) report a video memory write with the mirrored nametable bank and
// offset and the palette copy flag, and scanline items report the reloaded scroll
// address with fine X. Response fields that do not apply are zero. Configuration
// (mirroring mode, data write block) is written through the csr_ port; the user must
// write it only while the unit is idle, as the unit does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module video_register_scroll_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: [2:0] reg_select, [10:3] write_data, [11] first_line, [15:12] zero
   input  wire logic [vrsu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: [0] operation
   input  wire logic                             req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: [0] vram_write, [16:1] vram_address, [24:17] vram_data,
   //        [25] table_write, [27:26] table_bank, [37:28] table_offset,
   //        [38] palette_copy, [39] oam_write, [47:40] oam_address,
   //        [62:48] scroll_address, [65:63] scroll_fine_x, [71:66] zero
   output logic [vrsu_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // configuration write port
   input  wire logic                             csr_we,
   input  wire logic                             csr_index,
   input  wire logic [2:0]                       csr_wdata
);
   import vrsu_pkg::*;

   // Configuration
   logic [2:0]  mirror_mode_ff;
   logic        write_block_ff;

   // Scroll state
   logic        incr_32_ff,     incr_32_in;      // control byte one, bit 2
   logic [14:0] temp_addr_ff,   temp_addr_in;
   logic [14:0] view_addr_ff,   view_addr_in;
   logic [2:0]  fine_x_ff,      fine_x_in;
   logic        scroll_2nd_ff,  scroll_2nd_in;
   logic        addr_2nd_ff,    addr_2nd_in;
   logic [15:0] access_addr_ff, access_addr_in;
   logic [7:0]  oam_ptr_ff,     oam_ptr_in;

   // Output register
   logic        rsp_valid_ff,   rsp_valid_in;
   result_type  result_ff,      result_in;

   // Request fields
   logic        req_op;
   reg_sel_type req_sel;
   logic [7:0]  req_byte;
   logic        req_first;
   logic        req_accept;

   // Scanline helpers
   logic [14:0] line_addr;
   logic [14:0] line_next;

   assign req_op    = req_tuser;
   assign req_sel   = reg_sel_type'(req_tdata[2:0]);
   assign req_byte  = req_tdata[10:3];
   assign req_first = req_tdata[11];

   // Take a request whenever the output register frees up this cycle
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS_W){1'b0}}, result_ff};

   // Scanline reload: full on the first line, horizontal bits otherwise
   assign line_addr = req_first ? temp_addr_ff
                    : ((view_addr_ff & 15'h7BE0) | (temp_addr_ff & 15'h041F));

   // Vertical increment: fine Y, then coarse Y with the bottom-row wrap
   always_comb begin
      line_next = line_addr;
      if (line_addr[14:12] == 3'd7) begin
         line_next[14:12] = 3'd0;
         if (line_addr[9:5] == COARSE_Y_LAST) begin
            line_next[9:5] = 5'd0;
            line_next[11]  = ~line_addr[11];
         end else if (line_addr[9:5] == COARSE_Y_MAX) begin
            line_next[9:5] = 5'd0;
         end else begin
            line_next[9:5] = line_addr[9:5] + 5'd1;
         end
      end else begin
         line_next[14:12] = line_addr[14:12] + 3'd1;
      end
   end

   // Next state and result for the item at the request port
   always_comb begin
      incr_32_in     = incr_32_ff;
      temp_addr_in   = temp_addr_ff;
      view_addr_in   = view_addr_ff;
      fine_x_in      = fine_x_ff;
      scroll_2nd_in  = scroll_2nd_ff;
      addr_2nd_in    = addr_2nd_ff;
      access_addr_in = access_addr_ff;
      oam_ptr_in     = oam_ptr_ff;
      result_in      = '0;

      if (req_op == OP_SCANLINE) begin
         result_in.scroll_address = line_addr;
         result_in.scroll_fine_x  = fine_x_ff;
         view_addr_in             = line_next;
      end else begin
         case (req_sel)
            REG_CONTROL_ONE: begin
               incr_32_in          = req_byte[2];
               temp_addr_in[11:10] = req_byte[1:0];
            end
            REG_OAM_ADDR: begin
               oam_ptr_in = req_byte;
            end
            REG_OAM_DATA: begin
               result_in.oam_write   = 1'b1;
               result_in.oam_address = oam_ptr_ff;
               result_in.vram_data   = req_byte;
               oam_ptr_in            = oam_ptr_ff + 8'd1;
            end
            REG_SCROLL: begin
               if (!scroll_2nd_ff) begin
                  temp_addr_in[4:0] = req_byte[7:3];
                  fine_x_in         = req_byte[2:0];
               end else begin
                  temp_addr_in[9:5]   = req_byte[7:3];
                  temp_addr_in[14:12] = req_byte[2:0];
               end
               scroll_2nd_in = ~scroll_2nd_ff;
            end
            REG_ADDRESS: begin
               if (!addr_2nd_ff) begin
                  temp_addr_in[14:8] = {1'b0, req_byte[5:0]};
               end else begin
                  temp_addr_in[7:0] = req_byte;
                  view_addr_in      = {temp_addr_ff[14:8], req_byte};
                  access_addr_in    = {1'b0, temp_addr_ff[14:8], req_byte};
               end
               addr_2nd_in = ~addr_2nd_ff;
            end
            REG_DATA: begin
               if (!write_block_ff) begin
                  result_in.vram_write   = 1'b1;
                  result_in.vram_address = access_addr_ff;
                  result_in.vram_data    = req_byte;
                  // 0x3000..0x3EFF folds onto the same quadrant bits
                  if (access_addr_ff inside {[TABLE_LOW:TABLE_HIGH]}) begin
                     result_in.table_write  = 1'b1;
                     result_in.table_bank   = bank_map(mirror_mode_ff, access_addr_ff[11:10]);
                     result_in.table_offset = access_addr_ff[9:0];
                  end
                  result_in.palette_copy = (access_addr_ff == PALETTE_MIRROR);
                  access_addr_in = access_addr_ff + (incr_32_ff ? 16'd32 : 16'd1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the result until the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_mode_ff <= MIRROR_SINGLE_LOW;
         write_block_ff <= 1'b0;
         incr_32_ff     <= 1'b0;
         temp_addr_ff   <= '0;
         view_addr_ff   <= '0;
         fine_x_ff      <= '0;
         scroll_2nd_ff  <= 1'b0;
         addr_2nd_ff    <= 1'b0;
         access_addr_ff <= ACCESS_RESET;
         oam_ptr_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MIRROR_MODE: mirror_mode_ff <= csr_wdata;
               CSR_WRITE_BLOCK: write_block_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         // Advance the scroll state only on an accepted item
         if (req_accept) begin
            incr_32_ff     <= incr_32_in;
            temp_addr_ff   <= temp_addr_in;
            view_addr_ff   <= view_addr_in;
            fine_x_ff      <= fine_x_in;
            scroll_2nd_ff  <= scroll_2nd_in;
            addr_2nd_ff    <= addr_2nd_in;
            access_addr_ff <= access_addr_in;
            oam_ptr_ff     <= oam_ptr_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register: no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/vrsu_checker.sv =====
// ----------------------------------------------------------------------------
// vrsu_checker
// Port-level checks for the video register scroll unit.
// ----------------------------------------------------------------------------
`default_nettype none

module vrsu_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [vrsu_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import vrsu_pkg::*;

   // Every accepted request yields a response in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no response");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled response changed");

   // A sprite write and a video write never share one response
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[39]))
      else $error("sprite and video write in one response");

   // Nametable and palette flags only come with a video write
   a_table_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[25] || rsp_tdata[38]) |-> rsp_tdata[0])
      else $error("nametable or palette flag without video write");

endmodule

bind video_register_scroll_unit vrsu_checker u_vrsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
